// ===== rtl/spn_pkg.sv =====
// Shared types, codes and constants of the SPN block cipher engine.
`timescale 1ns / 1ps

package spn_pkg;

    localparam int MAX_ROUNDS_DEF = 16;
    localparam int CFG_W          = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int BLK_W          = 128;
    localparam int NUM_BYTES      = 16;
    localparam int NUM_NYB        = 32;
    localparam int KEY_ROWS       = 16;
    localparam int KEY_ADDR_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERMUTE_PERIOD = 2'd1;

    localparam logic [CFG_W-1:0] ROUND_COUNT_RST    = 5'd16;
    localparam logic [CFG_W-1:0] PERMUTE_PERIOD_RST = 5'd2;

    typedef enum logic [2:0] {
        OP_LOAD_SBOX = 3'd0,
        OP_LOAD_PERM = 3'd1,
        OP_LOAD_KEY  = 3'd2,
        OP_ENCRYPT   = 3'd3,
        OP_DECRYPT   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        MIX_NONE,
        MIX_PERM,
        MIX_SLIDE
    } t_mix;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_RUN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                  sbox_we;
        logic                  perm_we;
        logic                  key_we;
        logic                  capture;
        logic                  rd_en;
        logic                  first;
        logic                  decrypt;
        logic                  bypass;
        t_mix                  mix;
        logic [KEY_ADDR_W-1:0] key_addr;
        logic                  out_load;
    } t_dp_cmd;

endpackage

// ===== rtl/spn_block_cipher_128.sv =====
// Top level of the 128-bit SPN block cipher engine.
`timescale 1ns / 1ps
// Load requests are accepted back to back while the engine is idle.
// Encrypt and decrypt hold the input busy after acceptance: a key-bank prefetch, one round per
// cycle through sixteen registered S-box lanes, and a load of the output register.
// A result waits in the output register; a later one holds the input until it drains.
// Reset (synchronous, active low) restores round_count 16, permute_period 2; tables
// keep their contents and must be written before use.

module spn_block_cipher_128 #(
    parameter int MAX_ROUNDS = spn_pkg::MAX_ROUNDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_op,
    input  logic [7:0]                    i_index,
    input  logic [7:0]                    i_value,
    input  logic [63:0]                   i_block_hi,
    input  logic [63:0]                   i_block_lo,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [63:0]                   o_out_hi,
    output logic [63:0]                   o_out_lo,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spn_pkg::CFG_W-1:0]     i_cfg_data
);
    import spn_pkg::*;

    t_dp_cmd w_cmd;

    // sequence rounds, decode requests, own configuration and result valid
    spn_ctrl #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    // hold tables and block, run one round per cycle, drive the result register
    spn_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_index    (i_index),
        .i_value    (i_value),
        .i_block_hi (i_block_hi),
        .i_block_lo (i_block_lo),
        .o_out_hi   (o_out_hi),
        .o_out_lo   (o_out_lo)
    );

endmodule

// ===== rtl/spn_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module spn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/spn_dp.sv =====
// Datapath: table banks, block register, round logic and output register.
`timescale 1ns / 1ps

module spn_dp (
    input  logic                            i_clk,
    input  spn_pkg::t_dp_cmd                i_cmd,
    input  logic [7:0]                      i_index,
    input  logic [7:0]                      i_value,
    input  logic [63:0]                     i_block_hi,
    input  logic [63:0]                     i_block_lo,
    output logic [63:0]                     o_out_hi,
    output logic [63:0]                     o_out_lo
);
    import spn_pkg::*;

    logic [BLK_W-1:0] r_blk;
    logic [BLK_W-1:0] r_out;
    logic [4:0]       r_perm  [NUM_NYB];
    logic [4:0]       r_iperm [NUM_NYB];

    logic [BLK_W-1:0] w_srd, w_isrd, w_krd;
    logic [BLK_W-1:0] w_enc_mix, w_enc_nxt, w_enc_addr;
    logic [BLK_W-1:0] w_dx, w_dec_addr, w_result;

    function automatic logic [BLK_W-1:0] f_permute(input logic [BLK_W-1:0] b,
                                                   input logic [4:0] tbl [NUM_NYB]);
        logic [BLK_W-1:0] res;
        res = '0;
        for (int p = 0; p < NUM_NYB; p++) begin
            for (int i = 0; i < NUM_NYB; i++) begin
                if (tbl[i] == 5'(p)) begin
                    res[BLK_W-1-4*p -: 4] = b[BLK_W-1-4*i -: 4];
                end
            end
        end
        return res;
    endfunction

    function automatic logic [BLK_W-1:0] f_slide_fwd(input logic [BLK_W-1:0] b);
        logic [BLK_W-1:0] res;
        logic [7:0]       acc;
        res = '0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            acc = '0;
            for (int j = 0; j < NUM_BYTES; j++) begin
                if ((i == 0 && j != 0) || (i != 0 && j <= i)) begin
                    acc = acc ^ b[BLK_W-1-8*j -: 8];
                end
            end
            res[BLK_W-1-8*i -: 8] = acc;
        end
        return res;
    endfunction

    function automatic logic [BLK_W-1:0] f_slide_back(input logic [BLK_W-1:0] b);
        logic [BLK_W-1:0] res;
        logic [7:0]       c0;
        c0 = b[BLK_W-1 -: 8] ^ b[7:0];
        res = '0;
        res[BLK_W-1 -: 8] = c0;
        res[BLK_W-9 -: 8] = b[BLK_W-9 -: 8] ^ c0;
        for (int i = 2; i < NUM_BYTES; i++) begin
            res[BLK_W-1-8*i -: 8] = b[BLK_W-1-8*i -: 8] ^ b[BLK_W+7-8*i -: 8];
        end
        return res;
    endfunction

    // one lane per byte: forward box, inverse box, key row bank
    for (genvar n = 0; n < NUM_BYTES; n++) begin : g_lane
        spn_ram #(.WIDTH(8), .DEPTH(256)) u_sbox (
            .i_clk   (i_clk),
            .i_we    (i_cmd.sbox_we),
            .i_waddr (i_index),
            .i_wdata (i_value),
            .i_re    (i_cmd.rd_en),
            .i_raddr (w_enc_addr[BLK_W-1-8*n -: 8]),
            .o_rdata (w_srd[BLK_W-1-8*n -: 8])
        );
        spn_ram #(.WIDTH(8), .DEPTH(256)) u_isbox (
            .i_clk   (i_clk),
            .i_we    (i_cmd.sbox_we),
            .i_waddr (i_value),
            .i_wdata (i_index),
            .i_re    (i_cmd.rd_en),
            .i_raddr (w_dec_addr[BLK_W-1-8*n -: 8]),
            .o_rdata (w_isrd[BLK_W-1-8*n -: 8])
        );
        spn_ram #(.WIDTH(8), .DEPTH(KEY_ROWS)) u_key (
            .i_clk   (i_clk),
            .i_we    (i_cmd.key_we && (i_index[3:0] == 4'(n))),
            .i_waddr (i_index[7:4]),
            .i_wdata (i_value),
            .i_re    (i_cmd.rd_en),
            .i_raddr (i_cmd.key_addr),
            .o_rdata (w_krd[BLK_W-1-8*n -: 8])
        );
    end

    always_comb begin
        unique case (i_cmd.mix)
            MIX_PERM:  w_enc_mix = f_permute(w_srd, r_perm);
            MIX_SLIDE: w_enc_mix = f_slide_fwd(w_srd);
            default:   w_enc_mix = w_srd;
        endcase
        w_enc_nxt  = w_enc_mix ^ w_krd;
        w_enc_addr = i_cmd.first ? r_blk : w_enc_nxt;

        w_dx = (i_cmd.first ? r_blk : w_isrd) ^ w_krd;
        unique case (i_cmd.mix)
            MIX_PERM:  w_dec_addr = f_permute(w_dx, r_iperm);
            MIX_SLIDE: w_dec_addr = f_slide_back(w_dx);
            default:   w_dec_addr = w_dx;
        endcase

        if (i_cmd.bypass) begin
            w_result = r_blk;
        end else if (i_cmd.decrypt) begin
            w_result = w_isrd;
        end else begin
            w_result = w_enc_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_blk <= {i_block_hi, i_block_lo};
        end
        if (i_cmd.perm_we) begin
            r_perm[i_index[4:0]]  <= i_value[4:0];
            r_iperm[i_value[4:0]] <= i_index[4:0];
        end
        if (i_cmd.out_load) begin
            r_out <= w_result;
        end
    end

    assign o_out_hi = r_out[BLK_W-1 -: 64];
    assign o_out_lo = r_out[63:0];

endmodule

// ===== rtl/spn_ctrl.sv =====
// Controller: request decode, round sequencing, configuration and output valid.
`timescale 1ns / 1ps

module spn_ctrl #(
    parameter int MAX_ROUNDS = spn_pkg::MAX_ROUNDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [2:0]                      i_op,
    input  logic [7:0]                      i_index,
    input  logic [7:0]                      i_value,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_valid,
    input  logic [spn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spn_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                            o_cfg_ready,
    output spn_pkg::t_dp_cmd                o_cmd
);
    import spn_pkg::*;

    t_state r_state, n_state;
    logic [CFG_W-1:0]      r_round_count, r_period;
    logic [MAX_ROUNDS-1:0] r_perm_mask, n_perm_mask;
    logic [CFG_W-1:0]      r_rnd, n_rnd;
    logic                  r_first, n_first;
    logic                  r_dec, n_dec;
    logic                  r_bypass, n_bypass;
    logic                  r_out_valid, n_out_valid;

    logic             w_accept, w_crypt, w_perm_hit, w_out_free;
    logic [CFG_W-1:0] w_rounds;
    logic [9:0]       w_prod;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_crypt    = (i_op == OP_ENCRYPT) || (i_op == OP_DECRYPT);
    assign w_rounds   = (r_round_count > CFG_W'(MAX_ROUNDS)) ? CFG_W'(MAX_ROUNDS)
                                                             : r_round_count;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // rounds that take the permutation: multiples of the period, not of four
    always_comb begin
        n_perm_mask = '0;
        w_prod      = '0;
        for (int k = 1; k <= MAX_ROUNDS; k++) begin
            w_prod = 10'(k) * 10'(r_period);
            for (int i = 0; i < MAX_ROUNDS; i++) begin
                if (w_prod == 10'(i + 1) && ((i + 1) % 4) != 0) begin
                    n_perm_mask[i] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_perm_hit = 1'b0;
        for (int i = 0; i < MAX_ROUNDS; i++) begin
            if (r_rnd == CFG_W'(i + 1)) begin
                w_perm_hit = r_perm_mask[i];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_crypt) begin
                    n_state = ST_KEY;
                end
            end
            ST_KEY: begin
                if (w_rounds == '0 || (!r_dec && w_rounds == CFG_W'(1))) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if ((r_dec && r_rnd == CFG_W'(1)) ||
                    (!r_dec && r_rnd + CFG_W'(1) == w_rounds)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.sbox_we  = w_accept && (i_op == OP_LOAD_SBOX);
        o_cmd.perm_we  = w_accept && (i_op == OP_LOAD_PERM) &&
                         (i_index < 8'd32) && (i_value < 8'd32);
        o_cmd.key_we   = w_accept && (i_op == OP_LOAD_KEY);
        o_cmd.capture  = w_accept && w_crypt;
        o_cmd.decrypt  = r_dec;
        o_cmd.bypass   = r_bypass;
        o_cmd.first    = (r_state == ST_KEY) || r_first;
        o_cmd.rd_en    = (r_state == ST_KEY) || (r_state == ST_RUN);
        o_cmd.out_load = (r_state == ST_FINISH) && w_out_free;
        if (w_perm_hit) begin
            o_cmd.mix = MIX_PERM;
        end else if (r_rnd[1:0] == 2'd0 && r_rnd != '0) begin
            o_cmd.mix = MIX_SLIDE;
        end else begin
            o_cmd.mix = MIX_NONE;
        end
        if (r_state == ST_KEY) begin
            o_cmd.key_addr = r_dec ? KEY_ADDR_W'(w_rounds - CFG_W'(1)) : '0;
        end else if (r_dec) begin
            o_cmd.key_addr = KEY_ADDR_W'(r_rnd - CFG_W'(2));
        end else begin
            o_cmd.key_addr = KEY_ADDR_W'(r_rnd);
        end
    end

    // sequencing registers
    always_comb begin
        n_rnd       = r_rnd;
        n_first     = 1'b0;
        n_dec       = r_dec;
        n_bypass    = r_bypass;
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.capture) begin
            n_dec    = (i_op == OP_DECRYPT);
            n_bypass = 1'b0;
        end
        if (r_state == ST_KEY) begin
            n_bypass = (w_rounds == '0);
            n_rnd    = r_dec ? w_rounds : CFG_W'(1);
            n_first  = r_dec;
        end else if (r_state == ST_RUN) begin
            n_rnd = r_dec ? r_rnd - CFG_W'(1) : r_rnd + CFG_W'(1);
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_round_count <= ROUND_COUNT_RST;
            r_period      <= PERMUTE_PERIOD_RST;
            r_perm_mask   <= '0;
            r_rnd         <= '0;
            r_first       <= 1'b0;
            r_dec         <= 1'b0;
            r_bypass      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_perm_mask <= n_perm_mask;
            r_rnd       <= n_rnd;
            r_first     <= n_first;
            r_dec       <= n_dec;
            r_bypass    <= n_bypass;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_ROUND_COUNT) begin
                    r_round_count <= i_cfg_data;
                end else if (i_cfg_index == CFG_PERMUTE_PERIOD) begin
                    r_period <= i_cfg_data;
                end
            end
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.out_load && r_out_valid && i_out_stall))
        else $error("result overwritten while stalled");
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("result load did not complete");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_KEY))
        else $error("cipher request did not start");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd <= CFG_W'(MAX_ROUNDS))
        else $error("round index out of range");

endmodule
